>>> rtl/double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// double-ended queue assertion macros
// same-cycle and next-cycle implication checks on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// antecedent and consequent in the same cycle
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// action and status codes and field types of the double-ended queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_DUMP       = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

>>> rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed words kept as a ring buffer in one ram
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata       | tuser       | tlast
//  --------+-----+-------------+-------------+----------------------------
//  in_     | in  | value [31:0]| action [2:0]| -
//  out_    | out | word [31:0] | status [1:0]| last result of the action
//
//  push: the word is written into the ram on the accepting edge
//  pop: the ram read data register, then the result register
//  dump: one word a cycle from the ram read port while the output is not stalled
//  reset clears state, pointers, counters and valid flags; ram contents stay undefined
//  a stalled output holds the ram read data and pauses a dump in place
//
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire deq_pkg::word_t   in_tdata,   // [31:0] value
  input  wire deq_pkg::action_t in_tuser,   // [2:0] action
  // result channel
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output deq_pkg::word_t        out_tdata,  // [31:0] word
  output deq_pkg::status_t      out_tuser,  // [1:0] status
  output logic                  out_tlast
);

  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;   // ram index of the front word
  logic [CNT_W-1:0] occ_r, occ_nxt;       // stored words
  logic [CNT_W-1:0] total_r, total_nxt;   // results of the running read
  logic [CNT_W-1:0] iss_r, iss_nxt;       // reads issued
  logic [CNT_W-1:0] cons_r, cons_nxt;     // results delivered
  logic             rd_vld_r, rd_vld_nxt; // ram read data waits

  logic             out_valid_r, out_valid_nxt;
  word_t            out_word_r, out_word_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  logic             out_free;
  logic             full;
  logic             empty;
  logic             consume;
  logic             issue;
  logic [IDX_W-1:0] front_dec;

  logic             load;
  status_t          ld_status;
  word_t            ld_word;
  logic             ld_last;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  // ram index of the word at a given offset from the front
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign out_free  = !out_valid_r || out_tready;
  // one action at a time; the result register may drain in the same cycle
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign full      = (occ_r == CNT_W'(DEPTH));
  assign empty     = (occ_r == '0);
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;

  // a word in the ram output register moves to the result register
  assign consume   = (state_r == S_READ) && rd_vld_r && out_free;
  // next read while the ram output is free or being taken this cycle
  assign issue     = (state_r == S_READ) && (iss_r != total_r) && (!rd_vld_r || consume);

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    total_nxt  = total_r;
    iss_nxt    = iss_r;
    cons_nxt   = cons_r;
    rd_vld_nxt = rd_vld_r;
    wr_en      = 1'b0;
    wr_addr    = front_dec;
    rd_en      = 1'b0;
    rd_addr    = front_r;
    load       = 1'b0;
    ld_status  = ST_OK;
    ld_word    = '0;
    ld_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_tuser)
            ACT_PUSH_FRONT: begin
              load = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                occ_nxt   = occ_r + 1'b1;
              end
            end
            ACT_PUSH_BACK: begin
              load = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ring_pos(front_r, occ_r);
                occ_nxt = occ_r + 1'b1;
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = front_r;
                front_nxt  = ring_pos(front_r, CNT_W'(1));
                occ_nxt    = occ_r - 1'b1;
                total_nxt  = CNT_W'(1);
                iss_nxt    = CNT_W'(1);
                cons_nxt   = '0;
                rd_vld_nxt = 1'b1;
                state_nxt  = S_READ;
              end
            end
            ACT_POP_BACK: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = ring_pos(front_r, occ_r - 1'b1);
                occ_nxt    = occ_r - 1'b1;
                total_nxt  = CNT_W'(1);
                iss_nxt    = CNT_W'(1);
                cons_nxt   = '0;
                rd_vld_nxt = 1'b1;
                state_nxt  = S_READ;
              end
            end
            ACT_DUMP: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                // first read at the front, the rest issued from S_READ
                rd_en      = 1'b1;
                rd_addr    = front_r;
                total_nxt  = occ_r;
                iss_nxt    = CNT_W'(1);
                cons_nxt   = '0;
                rd_vld_nxt = 1'b1;
                state_nxt  = S_READ;
              end
            end
            default: begin
              // unused action codes are dropped
            end
          endcase
        end
      end
      S_READ: begin
        if (consume) begin
          load      = 1'b1;
          ld_status = ST_OK;
          ld_word   = word_t'(rd_data);
          ld_last   = (cons_r == total_r - 1'b1);
          cons_nxt  = cons_r + 1'b1;
          if (cons_r == total_r - 1'b1) begin
            state_nxt = S_IDLE;
          end
        end
        if (issue) begin
          rd_en   = 1'b1;
          rd_addr = ring_pos(front_r, iss_r);
          iss_nxt = iss_r + 1'b1;
        end
        rd_vld_nxt = issue || (rd_vld_r && !consume);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register: loaded on a new result, cleared when taken
  always_comb begin
    out_valid_nxt  = load || (out_valid_r && !out_tready);
    out_word_nxt   = load ? ld_word   : out_word_r;
    out_status_nxt = load ? ld_status : out_status_r;
    out_last_nxt   = load ? ld_last   : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      total_r     <= '0;
      iss_r       <= '0;
      cons_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      total_r     <= total_nxt;
      iss_r       <= iss_nxt;
      cons_r      <= cons_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // a read always comes at a later edge than any write it must see,
  // since only one action is in flight; no forwarding path is needed
  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_tdata),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`include "double_ended_queue_assert.svh"

  // pop on an empty queue answers with an empty status next cycle
  `DEQ_ASSERT_NXT(a_pop_empty, accept && empty && (in_tuser == ACT_POP_FRONT || in_tuser == ACT_POP_BACK), out_tvalid && out_tuser == ST_EMPTY && out_tlast, "pop on empty queue without empty result")

  // a successful push grows the queue by one word
  `DEQ_ASSERT_NXT(a_push_grow, accept && !full && (in_tuser == ACT_PUSH_FRONT || in_tuser == ACT_PUSH_BACK), occ_r == $past(occ_r) + 1'b1, "push did not grow occupancy")

  // delivering the last word of a read returns to idle
  `DEQ_ASSERT_NXT(a_last_idle, consume && ld_last, state_r == S_IDLE, "read sequence did not end after last word")

  // no ram read data is left waiting once idle, and occupancy stays within DEPTH
  `DEQ_ASSERT_IMP(a_idle_clean, state_r == S_IDLE, !rd_vld_r && occ_r <= CNT_W'(DEPTH), "stale read or bad occupancy while idle")

endmodule

`default_nettype wire

>>> tb/tb_double_ended_queue.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// self-checking bench for the ring-buffer deque: a short table of hand-picked
// actions with some typed-in results, then bursts of random fills, drains and
// mixed actions, scored beat by beat against typed results or a deque model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_double_ended_queue;

  import deq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 340;
  localparam int NUM_DIRECTED = 20;
  // a full dump plus the ram read and output register
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int IDLE_PCT     = 29;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  // action codes the block must ignore
  localparam action_t ACT_RSVD_5 = 3'd5;
  localparam action_t ACT_RSVD_6 = 3'd6;
  localparam action_t ACT_RSVD_7 = 3'd7;

  localparam word_t WORD_ZERO = 32'sh0000_0000;
  localparam word_t WORD_ONES = 32'shFFFF_FFFF;
  localparam word_t WORD_MAX  = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN  = 32'sh8000_0000;

  // table rows either carry their result or leave it to the model
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    status_t status;
    word_t   word;
    logic    last;
  } result_t;

  typedef struct packed {
    action_t action;
    word_t   value;
    logic    typed;
    status_t status;
    word_t   word;
  } stim_row_t;

  typedef enum logic [1:0] {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_kind_t;

  logic    clk;
  logic    rst_n;
  logic    in_tvalid;
  logic    in_tready;
  word_t   in_tdata;    // [31:0] value
  action_t in_tuser;    // [2:0] action
  logic    out_tvalid;
  logic    out_tready;
  word_t   out_tdata;   // [31:0] word
  status_t out_tuser;   // [1:0] status
  logic    out_tlast;

  // model of the deque contents, front at index 0
  word_t     deque_words[$];
  // results still owed by the block, oldest first
  result_t   pending_results[$];
  stim_row_t directed_rows[NUM_DIRECTED];
  int        fail_count = 0;
  // random idling on both channels, cleared for a quiet stretch
  bit        traffic_gaps = 1'b1;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("tb_double_ended_queue NOT OK");
    $finish;
  end

  function automatic result_t mk_result(status_t st, word_t w, logic lst);
    result_t r;
    r.status = st;
    r.word   = w;
    r.last   = lst;
    return r;
  endfunction

  // apply one accepted action to the model; owed results are queued when asked
  task automatic deque_apply(input action_t act, input word_t val, input bit record);
    result_t r;
    int      n;
    n = deque_words.size();
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (n >= DEPTH) begin
          r = mk_result(ST_FULL, WORD_ZERO, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) deque_words.push_front(val);
          else deque_words.push_back(val);
          r = mk_result(ST_OK, WORD_ZERO, 1'b1);
        end
        if (record) pending_results.push_back(r);
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (n == 0) r = mk_result(ST_EMPTY, WORD_ZERO, 1'b1);
        else if (act == ACT_POP_FRONT) r = mk_result(ST_OK, deque_words.pop_front(), 1'b1);
        else r = mk_result(ST_OK, deque_words.pop_back(), 1'b1);
        if (record) pending_results.push_back(r);
      end
      ACT_DUMP: begin
        // front to back, last flag on the final word; empty gives one beat
        if (n == 0) begin
          if (record) pending_results.push_back(mk_result(ST_EMPTY, WORD_ZERO, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            if (record) pending_results.push_back(mk_result(ST_OK, deque_words[i], i == n - 1));
        end
      end
      default: ; // unused codes: no result, no change
    endcase
  endtask

  // one input beat: optional idle cycles, then hold valid until accepted
  task automatic send_action(input action_t act, input word_t val, input bit record);
    if (traffic_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    deque_apply(act, val, record);
  endtask

  // sender holds off until the block has delivered everything owed
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return WORD_MIN;
    if (r < 10) return WORD_MAX;
    if (r < 14) return WORD_ZERO;
    return word_t'($urandom);
  endfunction

  // receiver backpressure
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= !traffic_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // score every result beat against the oldest owed result
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat, expected none, actual status %0d word %h last %0d",
                 $time, out_tuser, out_tdata, out_tlast);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          fail_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_tuser);
        end
        if (out_tdata !== want.word) begin
          fail_count++;
          $display("%0t: word mismatch, expected %h, actual %h",
                   $time, want.word, out_tdata);
        end
        if (out_tlast !== want.last) begin
          fail_count++;
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, want.last, out_tlast);
        end
      end
    end
  end

  initial begin
    burst_kind_t kind;
    action_t     act;
    int          counted;
    int          burst;
    int          span;
    int          pick;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= WORD_ZERO;
    in_tuser   <= ACT_PUSH_FRONT;

    // empty queue, extremes at both ends, ignored codes, drain back to empty
    directed_rows = '{
      '{ACT_POP_FRONT,  WORD_ZERO,     TYPED,     ST_EMPTY, WORD_ZERO},
      '{ACT_POP_BACK,   WORD_ZERO,     TYPED,     ST_EMPTY, WORD_ZERO},
      '{ACT_DUMP,       WORD_ZERO,     TYPED,     ST_EMPTY, WORD_ZERO},
      '{ACT_PUSH_BACK,  WORD_MAX,      TYPED,     ST_OK,    WORD_ZERO},
      '{ACT_PUSH_FRONT, WORD_MIN,      TYPED,     ST_OK,    WORD_ZERO},
      '{ACT_PUSH_BACK,  WORD_ONES,     TYPED,     ST_OK,    WORD_ZERO},
      '{ACT_PUSH_FRONT, WORD_ZERO,     TYPED,     ST_OK,    WORD_ZERO},
      '{ACT_DUMP,       WORD_ONES,     PREDICTED, ST_OK,    WORD_ZERO},
      '{ACT_RSVD_5,     32'sh5555_5555, PREDICTED, ST_OK,   WORD_ZERO},
      '{ACT_RSVD_6,     32'shAAAA_AAAA, PREDICTED, ST_OK,   WORD_ZERO},
      '{ACT_RSVD_7,     WORD_ONES,     PREDICTED, ST_OK,    WORD_ZERO},
      '{ACT_POP_FRONT,  WORD_ONES,     TYPED,     ST_OK,    WORD_ZERO},
      '{ACT_POP_BACK,   WORD_ZERO,     TYPED,     ST_OK,    WORD_ONES},
      '{ACT_POP_BACK,   WORD_ZERO,     TYPED,     ST_OK,    WORD_MAX},
      '{ACT_PUSH_BACK,  32'sh1234_5678, PREDICTED, ST_OK,   WORD_ZERO},
      '{ACT_DUMP,       WORD_ZERO,     PREDICTED, ST_OK,    WORD_ZERO},
      '{ACT_POP_FRONT,  WORD_ZERO,     TYPED,     ST_OK,    WORD_MIN},
      '{ACT_POP_FRONT,  WORD_ZERO,     TYPED,     ST_OK,    32'sh1234_5678},
      '{ACT_POP_FRONT,  WORD_ZERO,     TYPED,     ST_EMPTY, WORD_ZERO},
      '{ACT_DUMP,       WORD_ZERO,     TYPED,     ST_EMPTY, WORD_ZERO}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: typed rows owe their listed result, the rest the model's
    foreach (directed_rows[i]) begin
      send_action(directed_rows[i].action, directed_rows[i].value, !directed_rows[i].typed);
      if (directed_rows[i].typed)
        pending_results.push_back(mk_result(directed_rows[i].status, directed_rows[i].word, 1'b1));
    end
    wait_results_drained();

    // random bursts; the first fills past full, bursts 5..7 run without gaps
    counted = 0;
    burst   = 0;
    while (counted < RANDOM_ITEMS) begin
      if (burst == 0) kind = BURST_FILL;
      else begin
        pick = $urandom_range(0, 9);
        kind = (pick < 3) ? BURST_FILL : (pick < 5) ? BURST_DRAIN : BURST_MIXED;
      end
      traffic_gaps = !(burst >= 5 && burst <= 7);

      case (kind)
        BURST_FILL: begin
          // run into the full case, then at times dump the whole ring
          span = DEPTH - deque_words.size() + $urandom_range(1, 3);
          for (int k = 0; k < span; k++) begin
            act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            send_action(act, pick_value(), 1'b1);
            counted++;
          end
          if ($urandom_range(0, 1)) begin
            send_action(ACT_DUMP, pick_value(), 1'b1);
            counted++;
          end
        end
        BURST_DRAIN: begin
          // pop both ends until empty and a little past
          span = deque_words.size() + $urandom_range(1, 2);
          for (int k = 0; k < span; k++) begin
            act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
            send_action(act, pick_value(), 1'b1);
            counted++;
          end
          // at times let the result side run dry before going on
          if (burst % 2 == 0) wait_results_drained();
        end
        default: begin
          span = $urandom_range(8, 30);
          for (int k = 0; k < span; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) act = ACT_PUSH_FRONT;
            else if (pick < 56) act = ACT_PUSH_BACK;
            else if (pick < 72) act = ACT_POP_FRONT;
            else if (pick < 88) act = ACT_POP_BACK;
            else if (pick < 95) act = ACT_DUMP;
            else act = action_t'($urandom_range(ACT_RSVD_5, ACT_RSVD_7));
            send_action(act, pick_value(), 1'b1);
            // ignored codes do not count as stimulus
            if (act <= ACT_DUMP) counted++;
          end
        end
      endcase
      if (burst == 3) wait_results_drained();
      burst++;
    end
    traffic_gaps = 1'b1;

    // wait out everything owed, then a dump's worth of cycles for strays
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_double_ended_queue OK");
    end else begin
      $display("tb_double_ended_queue NOT OK");
    end
    $finish;
  end

endmodule
